@@ rtl/mqtt_pd_pkg.sv @@
// Shared types and constants of the MQTT control packet decoder.
`timescale 1ns / 1ps
`default_nettype none
package mqtt_pd_pkg;

  // Remaining length: 7 bits per byte, at most four bytes
  localparam int unsigned MaxLengthBytes = 4;
  localparam int unsigned LenDigitBits   = 7;
  localparam int unsigned LenWidth       = 28;
  localparam int unsigned LbcWidth       = 3;

  localparam logic [7:0] SubackLenReset = 8'd3;

  // Control packet types
  localparam logic [3:0] PktConnack  = 4'd2;
  localparam logic [3:0] PktPublish  = 4'd3;
  localparam logic [3:0] PktPuback   = 4'd4;
  localparam logic [3:0] PktPubrec   = 4'd5;
  localparam logic [3:0] PktPubrel   = 4'd6;
  localparam logic [3:0] PktPubcomp  = 4'd7;
  localparam logic [3:0] PktSuback   = 4'd9;
  localparam logic [3:0] PktUnsuback = 4'd11;

  // Result status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StInvalid   = 2'd1;
  localparam logic [1:0] StMalformed = 2'd2;

  localparam logic [1:0] QosReserved = 2'd3;

  typedef enum logic [1:0] {
    PhHeader,
    PhLength,
    PhBody
  } phase_e;

  // Everything the back end needs to build one summary
  typedef struct packed {
    logic [7:0]          type_flags;
    logic [LenWidth-1:0] rem_len;
    logic [LbcWidth-1:0] len_bytes;
    logic [1:0]          status;
    logic [15:0]         topic_cnt;
    logic [15:0]         msg_ident;
    logic [15:0]         first_bytes;
  } sum_rec_t;

endpackage
`default_nettype wire

@@ rtl/mqtt_pd_front.sv @@
// Byte parser: header, remaining length, body count and field capture.
`timescale 1ns / 1ps
`default_nettype none
module mqtt_pd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output mqtt_pd_pkg::sum_rec_t      rec_o
);

  mqtt_pd_pkg::phase_e phase_q, phase_d;
  logic [7:0]                              tf_q, tf_d;
  logic [mqtt_pd_pkg::LbcWidth-1:0]        lbc_q, lbc_d;
  logic [mqtt_pd_pkg::LenWidth-1:0]        acc_q, acc_d;
  logic [mqtt_pd_pkg::LenWidth-1:0]        cnt_q, cnt_d;
  logic [15:0]                             tl_q, tl_d;
  logic [15:0]                             pid_q, pid_d;
  logic [15:0]                             first_q, first_d;
  logic [1:0]                              status;
  logic                                    in_accept;

  assign in_ready_o = !q_full_i;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    tf_d    = tf_q;
    lbc_d   = lbc_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    tl_d    = tl_q;
    pid_d   = pid_q;
    first_d = first_q;
    status  = mqtt_pd_pkg::StOk;
    push_o  = 1'b0;
    if (in_accept) begin
      unique case (phase_q)
        mqtt_pd_pkg::PhHeader: begin
          tf_d    = data_byte_i;
          lbc_d   = '0;
          acc_d   = '0;
          cnt_d   = '0;
          tl_d    = '0;
          pid_d   = '0;
          first_d = '0;
          phase_d = mqtt_pd_pkg::PhLength;
        end
        mqtt_pd_pkg::PhLength: begin
          if (lbc_q < mqtt_pd_pkg::LbcWidth'(mqtt_pd_pkg::MaxLengthBytes)) begin
            acc_d = acc_q | (mqtt_pd_pkg::LenWidth'(data_byte_i[6:0])
                    << (5'(lbc_q) * 5'(mqtt_pd_pkg::LenDigitBits)));
          end
          lbc_d = lbc_q + 1'b1;
          if (data_byte_i[7]) begin
            if (lbc_d >= mqtt_pd_pkg::LbcWidth'(mqtt_pd_pkg::MaxLengthBytes)) begin
              // fourth length byte still continues: give up and resync on the next byte
              status  = mqtt_pd_pkg::StMalformed;
              push_o  = 1'b1;
              phase_d = mqtt_pd_pkg::PhHeader;
            end
          end else if (acc_d == '0) begin
            push_o  = 1'b1;
            phase_d = mqtt_pd_pkg::PhHeader;
          end else begin
            cnt_d   = '0;
            phase_d = mqtt_pd_pkg::PhBody;
          end
        end
        mqtt_pd_pkg::PhBody: begin
          if (cnt_q < mqtt_pd_pkg::LenWidth'(2)) begin
            if (tf_q[7:4] == mqtt_pd_pkg::PktPublish) begin
              tl_d = {tl_q[7:0], data_byte_i};
            end else begin
              first_d = {first_q[7:0], data_byte_i};
            end
          end else if (tf_q[7:4] == mqtt_pd_pkg::PktPublish) begin
            if (tf_q[2:1] != 2'd0 &&
                (cnt_q == mqtt_pd_pkg::LenWidth'(tl_q) + mqtt_pd_pkg::LenWidth'(2) ||
                 cnt_q == mqtt_pd_pkg::LenWidth'(tl_q) + mqtt_pd_pkg::LenWidth'(3))) begin
              pid_d = {pid_q[7:0], data_byte_i};
            end
          end else if (cnt_q == mqtt_pd_pkg::LenWidth'(2)) begin
            // third body byte: SUBACK return code
            tl_d = {8'd0, data_byte_i};
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_d >= acc_q) begin
            push_o  = 1'b1;
            phase_d = mqtt_pd_pkg::PhHeader;
          end
        end
        default: begin
          phase_d = mqtt_pd_pkg::PhHeader;
        end
      endcase
    end
    rec_o.type_flags  = tf_d;
    rec_o.rem_len     = acc_d;
    rec_o.len_bytes   = lbc_d;
    rec_o.status      = status;
    rec_o.topic_cnt   = tl_d;
    rec_o.msg_ident   = pid_d;
    rec_o.first_bytes = first_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mqtt_pd_pkg::PhHeader;
      tf_q    <= '0;
      lbc_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      tl_q    <= '0;
      pid_q   <= '0;
      first_q <= '0;
    end else begin
      phase_q <= phase_d;
      tf_q    <= tf_d;
      lbc_q   <= lbc_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      tl_q    <= tl_d;
      pid_q   <= pid_d;
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mqtt_pd_queue.sv @@
// Two-entry queue of packet summary records between parser and back end.
`timescale 1ns / 1ps
`default_nettype none
module mqtt_pd_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  mqtt_pd_pkg::sum_rec_t      rec_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output mqtt_pd_pkg::sum_rec_t      rec_o
);

  mqtt_pd_pkg::sum_rec_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mqtt_pd_back.sv @@
// Summary builder: per-type checks and field extraction into the output register.
`timescale 1ns / 1ps
`default_nettype none
module mqtt_pd_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_valid_i,
  input  mqtt_pd_pkg::sum_rec_t                    rec_i,
  output logic                                     pop_o,
  input  wire logic [7:0]                          suback_len_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [3:0]                               ctrl_type_o,
  output logic [3:0]                               header_flags_o,
  output logic [mqtt_pd_pkg::LenWidth-1:0]         remaining_length_o,
  output logic [1:0]                               status_o,
  output logic                                     sess_flag_o,
  output logic [7:0]                               return_code_o,
  output logic [15:0]                              msg_ident_o,
  output logic [1:0]                               qos_level_o,
  output logic [15:0]                              topic_size_o,
  output logic [2:0]                               topic_offset_o,
  output logic [16:0]                              data_offset_o,
  output logic [mqtt_pd_pkg::LenWidth-1:0]         data_length_o
);

  logic                                 valid_q;
  logic [3:0]                           ptype_q, flags_q;
  logic [mqtt_pd_pkg::LenWidth-1:0]     len_q, dlen_q;
  logic [1:0]                           st_q, qos_q;
  logic                                 sp_q;
  logic [7:0]                           rc_q;
  logic [15:0]                          pid_q, tl_q;
  logic [2:0]                           toff_q;
  logic [16:0]                          doff_q;

  logic [3:0]                           ptype, flags;
  logic [mqtt_pd_pkg::LenWidth-1:0]     len, dlen;
  logic [1:0]                           st, qos;
  logic                                 sp;
  logic [7:0]                           rc;
  logic [15:0]                          pid, tl;
  logic [2:0]                           toff;
  logic [16:0]                          doff;
  logic [17:0]                          need;

  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    ptype = rec_i.type_flags[7:4];
    flags = rec_i.type_flags[3:0];
    len   = rec_i.rem_len;
    st    = rec_i.status;
    sp    = 1'b0;
    rc    = '0;
    pid   = '0;
    qos   = '0;
    tl    = '0;
    toff  = '0;
    doff  = '0;
    dlen  = '0;
    need  = 18'd2 + 18'(rec_i.topic_cnt) + ((flags[2:1] != 2'd0) ? 18'd2 : 18'd0);
    if (st == mqtt_pd_pkg::StOk) begin
      unique case (ptype)
        mqtt_pd_pkg::PktConnack: begin
          if (len != mqtt_pd_pkg::LenWidth'(2) || flags != 4'd0) st = mqtt_pd_pkg::StInvalid;
          sp = rec_i.first_bytes[8];
          rc = rec_i.first_bytes[7:0];
        end
        mqtt_pd_pkg::PktPuback, mqtt_pd_pkg::PktPubrec,
        mqtt_pd_pkg::PktPubcomp, mqtt_pd_pkg::PktUnsuback: begin
          if (len != mqtt_pd_pkg::LenWidth'(2) || flags != 4'd0) st = mqtt_pd_pkg::StInvalid;
          pid = rec_i.first_bytes;
        end
        mqtt_pd_pkg::PktPubrel: begin
          if (len != mqtt_pd_pkg::LenWidth'(2) || flags != 4'd2) st = mqtt_pd_pkg::StInvalid;
          pid = rec_i.first_bytes;
        end
        mqtt_pd_pkg::PktSuback: begin
          if (len != mqtt_pd_pkg::LenWidth'(suback_len_i) || flags != 4'd0) begin
            st = mqtt_pd_pkg::StInvalid;
          end
          pid = rec_i.first_bytes;
          rc  = rec_i.topic_cnt[7:0];
        end
        mqtt_pd_pkg::PktPublish: begin
          qos = flags[2:1];
          tl  = rec_i.topic_cnt;
          if (qos == mqtt_pd_pkg::QosReserved || len < mqtt_pd_pkg::LenWidth'(2) ||
              len < mqtt_pd_pkg::LenWidth'(need)) begin
            st = mqtt_pd_pkg::StInvalid;
          end else begin
            pid  = rec_i.msg_ident;
            // offsets follow the length digits actually received
            toff = 3'd3 + rec_i.len_bytes;
            doff = 17'd1 + 17'(rec_i.len_bytes) + need[16:0];
            dlen = len - mqtt_pd_pkg::LenWidth'(need);
          end
        end
        default: begin
          st = mqtt_pd_pkg::StOk;
        end
      endcase
    end
    if (st != mqtt_pd_pkg::StOk) begin
      sp   = 1'b0;
      rc   = '0;
      pid  = '0;
      qos  = '0;
      tl   = '0;
      toff = '0;
      doff = '0;
      dlen = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ptype_q <= ptype;
      flags_q <= flags;
      len_q   <= len;
      st_q    <= st;
      sp_q    <= sp;
      rc_q    <= rc;
      pid_q   <= pid;
      qos_q   <= qos;
      tl_q    <= tl;
      toff_q  <= toff;
      doff_q  <= doff;
      dlen_q  <= dlen;
    end
  end

  assign out_valid_o        = valid_q;
  assign ctrl_type_o        = ptype_q;
  assign header_flags_o     = flags_q;
  assign remaining_length_o = len_q;
  assign status_o           = st_q;
  assign sess_flag_o        = sp_q;
  assign return_code_o      = rc_q;
  assign msg_ident_o        = pid_q;
  assign qos_level_o        = qos_q;
  assign topic_size_o       = tl_q;
  assign topic_offset_o     = toff_q;
  assign data_offset_o      = doff_q;
  assign data_length_o      = dlen_q;

endmodule
`default_nettype wire

@@ rtl/mqtt_packet_decoder_unit.sv @@
// MQTT 3.1.1 control packet decoder, top level.
//
// Takes the received stream one byte per cycle and gives one summary per packet:
// type and flags, decoded remaining length, a status (ok, invalid length or flags,
// malformed length encoding) and the captured fields of CONNACK, the acks, SUBACK
// and PUBLISH; topic and payload bytes are counted through, not passed on. The
// parser takes a byte every cycle as long as its two-entry summary queue has room,
// so the rate is one byte per cycle and only a stalled result port slows it. The
// summary of a packet goes from that queue into the output register. suback_expected_len
// is set through the configuration channel (reset value 3) and is to be written only
// while the decoder is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module mqtt_packet_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_suback_expected_len_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       ctrl_type_o,
  output logic [3:0]       header_flags_o,
  output logic [27:0]      remaining_length_o,
  output logic [1:0]       status_o,
  output logic             sess_flag_o,
  output logic [7:0]       return_code_o,
  output logic [15:0]      msg_ident_o,
  output logic [1:0]       qos_level_o,
  output logic [15:0]      topic_size_o,
  output logic [2:0]       topic_offset_o,
  output logic [16:0]      data_offset_o,
  output logic [27:0]      data_length_o
);

  logic [7:0]             suback_len_val_q;
  logic                   q_full, q_push, q_pop, q_valid;
  mqtt_pd_pkg::sum_rec_t  front_rec, queue_rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suback_len_val_q <= mqtt_pd_pkg::SubackLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      suback_len_val_q <= cfg_suback_expected_len_i;
    end
  end

  mqtt_pd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .rec_o       (front_rec)
  );

  mqtt_pd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (queue_rec)
  );

  mqtt_pd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .rec_i              (queue_rec),
    .pop_o              (q_pop),
    .suback_len_i       (suback_len_val_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .ctrl_type_o        (ctrl_type_o),
    .header_flags_o     (header_flags_o),
    .remaining_length_o (remaining_length_o),
    .status_o           (status_o),
    .sess_flag_o        (sess_flag_o),
    .return_code_o      (return_code_o),
    .msg_ident_o        (msg_ident_o),
    .qos_level_o        (qos_level_o),
    .topic_size_o       (topic_size_o),
    .topic_offset_o     (topic_offset_o),
    .data_offset_o      (data_offset_o),
    .data_length_o      (data_length_o)
  );

  // a summary is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("summary pushed into full queue");

  // any error status clears all per-type fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mqtt_pd_pkg::StOk |->
      msg_ident_o == 16'd0 && return_code_o == 8'd0 && data_length_o == 28'd0 &&
      data_offset_o == 17'd0 && sess_flag_o == 1'b0)
    else $error("error summary carries field data");

  // an accepted PUBLISH never reports the reserved qos
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mqtt_pd_pkg::StOk &&
      ctrl_type_o == mqtt_pd_pkg::PktPublish |-> qos_level_o != mqtt_pd_pkg::QosReserved)
    else $error("publish passed with reserved qos");

  // the output register only loads from a waiting queue entry
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // the configured length only changes on a configuration transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o) |=> $stable(suback_len_val_q))
    else $error("suback length changed without a write");

endmodule
`default_nettype wire

@@ verif/mqtt_packet_decoder_unit_tb.sv @@
// Self-checking testbench for the MQTT control packet decoder.
`timescale 1ns / 1ps
module mqtt_packet_decoder_unit_tb;

  localparam int unsigned PhaseBytes  = 180;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 2_500_000;

  typedef struct packed {
    logic [3:0]  ptype;
    logic [3:0]  flags;
    logic [27:0] rem_len;
    logic [1:0]  status;
    logic        sp;
    logic [7:0]  rc;
    logic [15:0] pid;
    logic [1:0]  qos;
    logic [15:0] tl;
    logic [2:0]  toff;
    logic [16:0] doff;
    logic [27:0] dlen;
  } pkt_summary_t;

  typedef struct {
    logic [7:0]   data;
    bit           typed;
    pkt_summary_t want;
  } stim_row_t;

  typedef enum logic [1:0] {
    SinkOpen,
    SinkRandom,
    SinkSparse
  } sink_mode_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_len   = mqtt_pd_pkg::SubackLenReset;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        hold_go   = 1'b0;

  logic        cfg_ready, in_ready, out_valid;
  logic [3:0]  ctrl_type, header_flags;
  logic [27:0] remaining_length, data_length;
  logic [1:0]  status, qos_level;
  logic        sess_flag;
  logic [7:0]  return_code;
  logic [15:0] msg_ident, topic_size;
  logic [2:0]  topic_offset;
  logic [16:0] data_offset;

  mqtt_packet_decoder_unit dut (
    .clk_i                     (clk),
    .rst_ni                    (rst_n),
    .cfg_valid_i               (cfg_valid),
    .cfg_ready_o               (cfg_ready),
    .cfg_suback_expected_len_i (cfg_len),
    .in_valid_i                (in_valid),
    .in_ready_o                (in_ready),
    .data_byte_i               (data_byte),
    .out_valid_o               (out_valid),
    .out_ready_i               (out_ready),
    .ctrl_type_o               (ctrl_type),
    .header_flags_o            (header_flags),
    .remaining_length_o        (remaining_length),
    .status_o                  (status),
    .sess_flag_o               (sess_flag),
    .return_code_o             (return_code),
    .msg_ident_o               (msg_ident),
    .qos_level_o               (qos_level),
    .topic_size_o              (topic_size),
    .topic_offset_o            (topic_offset),
    .data_offset_o             (data_offset),
    .data_length_o             (data_length)
  );

  // Decoder state as the predictor sees it
  mqtt_pd_pkg::phase_e dec_phase = mqtt_pd_pkg::PhHeader;
  logic [2:0]  dec_len_cnt   = '0;
  logic [27:0] dec_len_acc   = '0;
  logic [27:0] dec_body_cnt  = '0;
  logic [7:0]  dec_tf        = '0;
  logic [15:0] dec_topic_cnt = '0;
  logic [15:0] dec_pid       = '0;
  logic [15:0] dec_first     = '0;
  logic [7:0]  suback_cfg    = mqtt_pd_pkg::SubackLenReset;

  pkt_summary_t summary_q[$];
  logic [7:0]   pkt_q[$];
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left  = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic pkt_summary_t head_summary(input logic [3:0] ptype,
      input logic [3:0] flags, input logic [27:0] len, input logic [1:0] st,
      input logic sp, input logic [7:0] rc, input logic [15:0] pid);
    pkt_summary_t s;
    s = '0;
    s.ptype = ptype;
    s.flags = flags;
    s.rem_len = len;
    s.status = st;
    s.sp = sp;
    s.rc = rc;
    s.pid = pid;
    return s;
  endfunction

  // Close the current packet; leaves the parser waiting for a header byte
  function automatic pkt_summary_t summarise_packet(input logic [1:0] st_in);
    pkt_summary_t s;
    logic [1:0]   st;
    int unsigned  need;
    s = '0;
    st = st_in;
    if (st == mqtt_pd_pkg::StOk) begin
      case (dec_tf[7:4])
        mqtt_pd_pkg::PktConnack: begin
          if (dec_len_acc != 28'd2 || dec_tf[3:0] != 4'h0) st = mqtt_pd_pkg::StInvalid;
          s.sp = dec_first[8];
          s.rc = dec_first[7:0];
        end
        mqtt_pd_pkg::PktPuback, mqtt_pd_pkg::PktPubrec, mqtt_pd_pkg::PktPubcomp,
        mqtt_pd_pkg::PktUnsuback: begin
          if (dec_len_acc != 28'd2 || dec_tf[3:0] != 4'h0) st = mqtt_pd_pkg::StInvalid;
          s.pid = dec_first;
        end
        mqtt_pd_pkg::PktPubrel: begin
          if (dec_len_acc != 28'd2 || dec_tf[3:0] != 4'h2) st = mqtt_pd_pkg::StInvalid;
          s.pid = dec_first;
        end
        mqtt_pd_pkg::PktSuback: begin
          if (dec_len_acc != 28'(suback_cfg) || dec_tf[3:0] != 4'h0) begin
            st = mqtt_pd_pkg::StInvalid;
          end
          s.pid = dec_first;
          s.rc = dec_topic_cnt[7:0];
        end
        mqtt_pd_pkg::PktPublish: begin
          s.qos = dec_tf[2:1];
          s.tl = dec_topic_cnt;
          need = 2 + dec_topic_cnt + ((s.qos != 2'd0) ? 2 : 0);
          if (s.qos == mqtt_pd_pkg::QosReserved || dec_len_acc < 2 || dec_len_acc < need) begin
            st = mqtt_pd_pkg::StInvalid;
          end else begin
            s.pid = dec_pid;
            s.toff = 3'(3 + dec_len_cnt);
            s.doff = 17'(1 + dec_len_cnt + need);
            s.dlen = 28'(dec_len_acc - need);
          end
        end
        default: ;
      endcase
    end
    if (st != mqtt_pd_pkg::StOk) s = '0;
    s.ptype = dec_tf[7:4];
    s.flags = dec_tf[3:0];
    s.rem_len = dec_len_acc;
    s.status = st;
    dec_phase = mqtt_pd_pkg::PhHeader;
    return s;
  endfunction

  function automatic void capture_body_byte(input logic [7:0] b);
    if (dec_body_cnt < 2) begin
      if (dec_tf[7:4] == mqtt_pd_pkg::PktPublish) dec_topic_cnt = {dec_topic_cnt[7:0], b};
      else dec_first = {dec_first[7:0], b};
    end else if (dec_tf[7:4] == mqtt_pd_pkg::PktPublish) begin
      // packet id sits right behind the topic name when qos is nonzero
      if (dec_tf[2:1] != 2'd0 && (32'(dec_body_cnt) == 32'(dec_topic_cnt) + 2 ||
                                  32'(dec_body_cnt) == 32'(dec_topic_cnt) + 3))
        dec_pid = {dec_pid[7:0], b};
    end else if (dec_body_cnt == 2) begin
      dec_topic_cnt = {8'h00, b};
    end
  endfunction

  function automatic void decode_stream_byte(input logic [7:0] b, output bit got,
                                             output pkt_summary_t res);
    got = 1'b0;
    res = '0;
    case (dec_phase)
      mqtt_pd_pkg::PhLength: begin
        if (dec_len_cnt < mqtt_pd_pkg::MaxLengthBytes)
          dec_len_acc = dec_len_acc |
                        28'(32'(b[6:0]) << (mqtt_pd_pkg::LenDigitBits * dec_len_cnt));
        dec_len_cnt = dec_len_cnt + 3'd1;
        if (b[7]) begin
          if (dec_len_cnt >= mqtt_pd_pkg::MaxLengthBytes) begin
            res = summarise_packet(mqtt_pd_pkg::StMalformed);
            got = 1'b1;
          end
        end else if (dec_len_acc == '0) begin
          res = summarise_packet(mqtt_pd_pkg::StOk);
          got = 1'b1;
        end else begin
          dec_phase = mqtt_pd_pkg::PhBody;
          dec_body_cnt = '0;
        end
      end
      mqtt_pd_pkg::PhBody: begin
        capture_body_byte(b);
        dec_body_cnt = dec_body_cnt + 28'd1;
        if (dec_body_cnt >= dec_len_acc) begin
          res = summarise_packet(mqtt_pd_pkg::StOk);
          got = 1'b1;
        end
      end
      default: begin
        dec_tf = b;
        dec_len_cnt = '0;
        dec_len_acc = '0;
        dec_body_cnt = '0;
        dec_topic_cnt = '0;
        dec_pid = '0;
        dec_first = '0;
        dec_phase = mqtt_pd_pkg::PhLength;
      end
    endcase
  endfunction

  // Variable-length encoding, padded with zero digits up to four bytes when asked
  function automatic void push_length(input int unsigned len, input int unsigned extra);
    logic [7:0]  digit;
    int unsigned rest, ndig, pad;
    rest = len;
    ndig = 0;
    do begin
      digit = 8'(rest % 128);
      rest = rest / 128;
      if (rest != 0) digit[7] = 1'b1;
      pkt_q.push_back(digit);
      ndig++;
    end while (rest != 0);
    pad = (extra > mqtt_pd_pkg::MaxLengthBytes - ndig) ?
          mqtt_pd_pkg::MaxLengthBytes - ndig : extra;
    if (pad > 0) begin
      pkt_q[pkt_q.size() - 1] = pkt_q[pkt_q.size() - 1] | 8'h80;
      repeat (pad - 1) pkt_q.push_back(8'h80);
      pkt_q.push_back(8'h00);
    end
  endfunction

  function automatic void push_random(input int unsigned n);
    repeat (n) pkt_q.push_back(8'($urandom));
  endfunction

  function automatic void make_packet();
    logic [3:0]  ack_types[5] = '{mqtt_pd_pkg::PktPuback, mqtt_pd_pkg::PktPubrec,
                                  mqtt_pd_pkg::PktPubrel, mqtt_pd_pkg::PktPubcomp,
                                  mqtt_pd_pkg::PktUnsuback};
    logic [3:0]  chk_types[7] = '{mqtt_pd_pkg::PktConnack, mqtt_pd_pkg::PktPuback,
                                  mqtt_pd_pkg::PktPubrec, mqtt_pd_pkg::PktPubrel,
                                  mqtt_pd_pkg::PktPubcomp, mqtt_pd_pkg::PktSuback,
                                  mqtt_pd_pkg::PktUnsuback};
    logic [7:0]  body[$];
    logic [3:0]  ptype;
    logic [1:0]  qos;
    int unsigned pick, pad, len, tl;
    pkt_q.delete();
    pick = $urandom_range(0, 99);
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (pick < 10) begin
      pkt_q.push_back({mqtt_pd_pkg::PktConnack, 4'h0});
      push_length(2, pad);
      push_random(2);
    end else if (pick < 35) begin
      qos = ($urandom_range(0, 15) == 0) ? mqtt_pd_pkg::QosReserved :
            2'($urandom_range(0, 2));
      tl = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
      body.push_back(8'(tl >> 8));
      body.push_back(8'(tl));
      repeat (tl + ((qos != 2'd0) ? 2 : 0) + $urandom_range(0, 16))
        body.push_back(8'($urandom));
      len = body.size();
      // now and then a truncated length, which can be too short for topic and packet id
      if ($urandom_range(0, 7) == 0) len = $urandom_range(0, len - 1);
      pkt_q.push_back({mqtt_pd_pkg::PktPublish, 1'($urandom), qos, 1'($urandom)});
      push_length(len, pad);
      for (int i = 0; i < len; i++) pkt_q.push_back(body[i]);
    end else if (pick < 55) begin
      ptype = ack_types[$urandom_range(0, 4)];
      pkt_q.push_back({ptype, (ptype == mqtt_pd_pkg::PktPubrel) ? 4'h2 : 4'h0});
      push_length(2, pad);
      push_random(2);
    end else if (pick < 68) begin
      len = ($urandom_range(0, 3) != 0) ? suback_cfg : $urandom_range(0, 6);
      pkt_q.push_back({mqtt_pd_pkg::PktSuback, 4'h0});
      push_length(len, pad);
      push_random(len);
    end else if (pick < 80) begin
      // known type with random flags and length
      len = $urandom_range(0, 4);
      pkt_q.push_back({chk_types[$urandom_range(0, 6)], 4'($urandom)});
      push_length(len, pad);
      push_random(len);
    end else if (pick < 90) begin
      len = $urandom_range(0, 8);
      push_random(1);
      push_length(len, pad);
      push_random(len);
    end else if (pick < 95) begin
      push_random(1);
      repeat (mqtt_pd_pkg::MaxLengthBytes) pkt_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
    end else begin
      push_random(1);
      push_length(0, pad);
    end
  endfunction

  function automatic void cmp_field(input string name, input longint unsigned want,
                                    input longint unsigned seen);
    if (want != seen) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
      fail_count++;
    end
  endfunction

  function automatic void check_summary(input pkt_summary_t e);
    cmp_field("ctrl_type", e.ptype, ctrl_type);
    cmp_field("header_flags", e.flags, header_flags);
    cmp_field("remaining_length", e.rem_len, remaining_length);
    cmp_field("status", e.status, status);
    cmp_field("sess_flag", e.sp, sess_flag);
    cmp_field("return_code", e.rc, return_code);
    cmp_field("msg_ident", e.pid, msg_ident);
    cmp_field("qos_level", e.qos, qos_level);
    cmp_field("topic_size", e.tl, topic_size);
    cmp_field("topic_offset", e.toff, topic_offset);
    cmp_field("data_offset", e.doff, data_offset);
    cmp_field("data_length", e.dlen, data_length);
  endfunction

  // One byte transfer; the sender may idle between bursts
  task automatic feed(input logic [7:0] b, input bit typed, input pkt_summary_t want);
    int unsigned  gap;
    bit           got;
    pkt_summary_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_stream_byte(b, got, res);
    if (got) summary_q.push_back(typed ? want : res);
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) feed(pkt_q[i], 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_suback_len(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_len <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    suback_cfg = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (summary_q.size() == 0) begin
        $error("result transfer with nothing expected (type 0x%0h)", ctrl_type);
        fail_count++;
      end else begin
        check_summary(summary_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    sink_mode_e  mode = SinkOpen;
    int unsigned mode_left = 0;
    int unsigned tick = 0;
    bit          hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        // long back-pressure so the result queue fills and input transfers stop
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        SinkOpen:   out_ready <= 1'b1;
        SinkRandom: out_ready <= 1'($urandom);
        default:    out_ready <= (tick % 4 == 0);
      endcase
    end
  end

  initial begin : stimulus
    stim_row_t   directed_tbl[29];
    logic [7:0]  cfg_plan[5];
    int unsigned sent;
    directed_tbl = '{
      '{8'h20, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'h01, 1'b0, '0},
      '{8'hFF, 1'b1, head_summary(mqtt_pd_pkg::PktConnack, 4'h0, 28'd2, mqtt_pd_pkg::StOk,
                                  1'b1, 8'hFF, 16'h0)},
      // five-byte length: malformed
      '{8'h30, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b1, head_summary(mqtt_pd_pkg::PktPublish, 4'h0, 28'hFFF_FFFF,
                                  mqtt_pd_pkg::StMalformed, 1'b0, 8'h00, 16'h0)},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b1, head_summary(4'hF, 4'hF, 28'd0, mqtt_pd_pkg::StOk, 1'b0, 8'h00,
                                  16'h0)},
      // qos 1 publish, length sent in two bytes
      '{8'h32, 1'b0, '0}, '{8'h86, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h41, 1'b0, '0},
      '{8'h12, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'hAA, 1'b0, '0},
      '{8'h60, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'hAB, 1'b0, '0},
      '{8'hCD, 1'b1, head_summary(mqtt_pd_pkg::PktPubrel, 4'h0, 28'd2,
                                  mqtt_pd_pkg::StInvalid, 1'b0, 8'h00, 16'h0)},
      '{8'h90, 1'b0, '0}, '{8'h03, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h05, 1'b0, '0},
      '{8'h80, 1'b1, head_summary(mqtt_pd_pkg::PktSuback, 4'h0, 28'd3, mqtt_pd_pkg::StOk,
                                  1'b0, 8'h80, 16'h0005)}
    };
    cfg_plan = '{8'd255, 8'd2, 8'd0, 8'd0, mqtt_pd_pkg::SubackLenReset};
    cfg_plan[3] = 8'($urandom_range(4, 254));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[i]) feed(directed_tbl[i].data, directed_tbl[i].typed,
                                   directed_tbl[i].want);

    hold_go <= 1'b1;
    for (int ph = 0; ph <= 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_suback_len(cfg_plan[ph - 1]);
      end
      sent = 0;
      while (sent < PhaseBytes) begin
        make_packet();
        sent += pkt_q.size();
        send_packet();
      end
    end

    // qos 1 publish with the length padded to four bytes: topic offset at its top value
    pkt_q.delete();
    pkt_q.push_back({mqtt_pd_pkg::PktPublish, 4'h2});
    push_length(16, mqtt_pd_pkg::MaxLengthBytes);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'h08);
    push_random(8 + 2 + 4);
    send_packet();

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
